>>> sv/ctlt_pkg.sv
`default_nettype none

package ctlt_pkg;

  localparam int unsigned LINE_BYTES_DEF = 512;

  localparam logic [2:0] PH_NAME = 3'd0;
  localparam logic [2:0] PH_ARGS = 3'd1;
  localparam logic [2:0] PH_CR   = 3'd2;
  localparam logic [2:0] PH_DONE = 3'd3;
  localparam logic [2:0] PH_BAD  = 3'd4;

  localparam logic FUNC_FEED    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [2:0] phase;
    logic [2:0] prev_phase;
    logic       arg_one_valid;
    logic       arg_two_valid;
  } ctlt_ctrl_t;

endpackage

`default_nettype wire

>>> sv/ctlt_in_if.sv
`default_nettype none

interface ctlt_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] in_byte;

  modport source (output valid, output func, output in_byte, input ready);
  modport sink   (input valid, input func, input in_byte, output ready);
endinterface

`default_nettype wire

>>> sv/ctlt_out_if.sv
`default_nettype none

interface ctlt_out_if #(
  parameter int unsigned LINE_BYTES = ctlt_pkg::LINE_BYTES_DEF
);
  localparam int unsigned IdxW = $clog2(LINE_BYTES);
  localparam int unsigned CntW = $clog2(LINE_BYTES + 1);

  logic            valid;
  logic            ready;
  logic [2:0]      phase;
  logic            store_valid;
  logic [IdxW-1:0] store_index;
  logic [7:0]      store_byte;
  logic            clear_before;
  logic            first_arg_present;
  logic [IdxW-1:0] first_arg_offset;
  logic            second_arg_present;
  logic [IdxW-1:0] second_arg_offset;
  logic [CntW-1:0] line_length;
  logic            overflow;

  modport source (
    output valid, output phase, output store_valid, output store_index,
    output store_byte, output clear_before, output first_arg_present,
    output first_arg_offset, output second_arg_present, output second_arg_offset,
    output line_length, output overflow, input ready
  );
  modport sink (
    input valid, input phase, input store_valid, input store_index,
    input store_byte, input clear_before, input first_arg_present,
    input first_arg_offset, input second_arg_present, input second_arg_offset,
    input line_length, input overflow, output ready
  );
endinterface

`default_nettype wire

>>> sv/text_command_line_tokenizer_core.sv
`default_nettype none

// Command line tokenizer: takes one byte (or a restart) per transfer on in_i and returns
// one result per byte on res_o via an input register and a result register. One byte per
// cycle is sustained while res_o is not stalled, as the phase, length and argument registers
// update once per byte; the two registers let both sides stall independently.
module text_command_line_tokenizer_core #(
  parameter int unsigned LINE_BYTES = ctlt_pkg::LINE_BYTES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ctlt_in_if.sink   in_i,
  ctlt_out_if.source res_o
);
  import ctlt_pkg::*;

  localparam int unsigned IdxW = $clog2(LINE_BYTES);
  localparam int unsigned CntW = $clog2(LINE_BYTES + 1);

  logic            s1_valid_q;
  logic            s1_func_q;
  logic [7:0]      s1_byte_q;
  logic            out_valid_q;
  logic            adv;
  logic            in_rdy;

  ctlt_ctrl_t      ctrl_q, ctrl_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] a1_q, a1_d;
  logic [IdxW-1:0] a2_q, a2_d;

  logic            st_valid_d, st_valid_q;
  logic [IdxW-1:0] st_index_d, st_index_q;
  logic [7:0]      st_byte_d, st_byte_q;
  logic            clr_d, clr_q;
  logic            ovf_d, ovf_q;

  assign adv    = !out_valid_q || res_o.ready;
  assign in_rdy = !s1_valid_q || adv;
  assign in_i.ready = in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_rdy) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_i.valid) begin
      s1_func_q <= in_i.func;
      s1_byte_q <= in_i.in_byte;
    end
  end

  ctlt_step #(.LINE_BYTES(LINE_BYTES)) u_step (
    .func_i         (s1_func_q),
    .byte_i         (s1_byte_q),
    .ctrl_i         (ctrl_q),
    .count_i        (count_q),
    .arg_one_start_i(a1_q),
    .arg_two_start_i(a2_q),
    .ctrl_o         (ctrl_d),
    .count_o        (count_d),
    .arg_one_start_o(a1_d),
    .arg_two_start_o(a2_d),
    .store_valid_o  (st_valid_d),
    .store_index_o  (st_index_d),
    .store_byte_o   (st_byte_d),
    .clear_before_o (clr_d),
    .overflow_o     (ovf_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '{phase: PH_NAME, prev_phase: PH_NAME,
                       arg_one_valid: 1'b0, arg_two_valid: 1'b0};
      count_q     <= '0;
      a1_q        <= '0;
      a2_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        ctrl_q  <= ctrl_d;
        count_q <= count_d;
        a1_q    <= a1_d;
        a2_q    <= a2_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      st_valid_q <= st_valid_d;
      st_index_q <= st_index_d;
      st_byte_q  <= st_byte_d;
      clr_q      <= clr_d;
      ovf_q      <= ovf_d;
    end
  end

  // state registers hold the post-update values of the last transfer
  assign res_o.valid              = out_valid_q;
  assign res_o.phase              = ctrl_q.phase;
  assign res_o.store_valid        = st_valid_q;
  assign res_o.store_index        = st_index_q;
  assign res_o.store_byte         = st_byte_q;
  assign res_o.clear_before       = clr_q;
  assign res_o.first_arg_present  = ctrl_q.arg_one_valid;
  assign res_o.first_arg_offset   = a1_q;
  assign res_o.second_arg_present = ctrl_q.arg_two_valid;
  assign res_o.second_arg_offset  = a2_q;
  assign res_o.line_length        = count_q;
  assign res_o.overflow           = ovf_q;

endmodule

`default_nettype wire

>>> sv/ctlt_step.sv
`default_nettype none

module ctlt_step #(
  parameter int unsigned LINE_BYTES = ctlt_pkg::LINE_BYTES_DEF,
  localparam int unsigned IdxW = $clog2(LINE_BYTES),
  localparam int unsigned CntW = $clog2(LINE_BYTES + 1)
) (
  input  wire logic                func_i,
  input  wire logic [7:0]          byte_i,
  input  wire ctlt_pkg::ctlt_ctrl_t ctrl_i,
  input  wire logic [CntW-1:0]     count_i,
  input  wire logic [IdxW-1:0]     arg_one_start_i,
  input  wire logic [IdxW-1:0]     arg_two_start_i,
  output      ctlt_pkg::ctlt_ctrl_t ctrl_o,
  output      logic [CntW-1:0]     count_o,
  output      logic [IdxW-1:0]     arg_one_start_o,
  output      logic [IdxW-1:0]     arg_two_start_o,
  output      logic                store_valid_o,
  output      logic [IdxW-1:0]     store_index_o,
  output      logic [7:0]          store_byte_o,
  output      logic                clear_before_o,
  output      logic                overflow_o
);
  import ctlt_pkg::*;

  logic            stored;
  logic [IdxW-1:0] pos;
  logic [7:0]      val;
  logic            wr_clear;
  logic            reset_after;
  logic            is_sp;
  logic            is_cr;
  ctlt_ctrl_t      nc;
  logic [IdxW-1:0] n_a1;
  logic [IdxW-1:0] n_a2;

  assign stored = count_i < CntW'(LINE_BYTES);
  assign pos    = count_i[IdxW-1:0];
  assign is_sp  = byte_i == CH_SPACE;
  assign is_cr  = byte_i == CH_CR;

  always_comb begin
    nc          = ctrl_i;
    n_a1        = arg_one_start_i;
    n_a2        = arg_two_start_i;
    val         = byte_i;
    wr_clear    = 1'b0;
    reset_after = 1'b0;
    unique case (ctrl_i.phase)
      PH_NAME: begin
        if (is_sp) begin
          nc.prev_phase = ctrl_i.phase;
          nc.phase      = PH_ARGS;
          val           = CH_NUL;
        end else if (is_cr) begin
          nc.phase = PH_CR;
          val      = CH_NUL;
        end
      end
      PH_CR: begin
        if (byte_i == CH_LF) begin
          if (ctrl_i.prev_phase == PH_BAD) begin
            nc.phase    = PH_NAME;
            reset_after = 1'b1;
          end else begin
            nc.phase = PH_DONE;
            val      = CH_NUL;
            wr_clear = stored && (pos != '0);
          end
        end else begin
          nc.phase = PH_BAD;
        end
        nc.prev_phase = PH_CR;
      end
      PH_ARGS: begin
        if (!is_sp && byte_i != CH_TAB && !is_cr && ctrl_i.prev_phase == PH_NAME) begin
          if (stored) begin
            if (!ctrl_i.arg_one_valid) begin
              nc.arg_one_valid = 1'b1;
              n_a1             = pos;
            end else begin
              nc.arg_two_valid = 1'b1;
              n_a2             = pos;
            end
          end
          nc.prev_phase = PH_ARGS;
        end else if (is_sp && ctrl_i.prev_phase == PH_ARGS) begin
          nc.prev_phase = PH_NAME;
          val           = CH_NUL;
        end else if (is_cr) begin
          nc.prev_phase = PH_ARGS;
          nc.phase      = PH_CR;
        end
      end
      PH_BAD: begin
        nc.prev_phase = PH_BAD;
        nc.phase      = is_cr ? PH_CR : PH_BAD;
      end
      default: ;
    endcase
  end

  always_comb begin
    ctrl_o          = nc;
    count_o         = stored ? count_i + CntW'(1) : count_i;
    arg_one_start_o = n_a1;
    arg_two_start_o = n_a2;
    store_valid_o   = stored;
    store_index_o   = stored ? pos : '0;
    store_byte_o    = stored ? val : CH_NUL;
    clear_before_o  = wr_clear;
    overflow_o      = !stored;
    if (reset_after) begin
      ctrl_o.arg_one_valid = 1'b0;
      ctrl_o.arg_two_valid = 1'b0;
      count_o              = '0;
      arg_one_start_o      = '0;
      arg_two_start_o      = '0;
    end
    if (func_i == FUNC_RESTART) begin
      ctrl_o          = '{phase: PH_NAME, prev_phase: PH_NAME,
                          arg_one_valid: 1'b0, arg_two_valid: 1'b0};
      count_o         = '0;
      arg_one_start_o = '0;
      arg_two_start_o = '0;
      store_valid_o   = 1'b0;
      store_index_o   = '0;
      store_byte_o    = CH_NUL;
      clear_before_o  = 1'b0;
      overflow_o      = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> sv/ctlt_checker.sv
`default_nettype none

module ctlt_checker #(
  parameter int unsigned LINE_BYTES = ctlt_pkg::LINE_BYTES_DEF,
  localparam int unsigned IdxW = $clog2(LINE_BYTES),
  localparam int unsigned CntW = $clog2(LINE_BYTES + 1)
) (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            valid_i,
  input wire logic            ready_i,
  input wire logic [2:0]      phase_i,
  input wire logic            store_valid_i,
  input wire logic [IdxW-1:0] store_index_i,
  input wire logic [7:0]      store_byte_i,
  input wire logic            clear_before_i,
  input wire logic            first_arg_present_i,
  input wire logic            second_arg_present_i,
  input wire logic [CntW-1:0] line_length_i,
  input wire logic            overflow_i
);
  import ctlt_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("result transfer dropped while stalled");

  a_index_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && store_valid_i && line_length_i != '0
      |-> CntW'(store_index_i) + CntW'(1) == line_length_i)
    else $error("store index does not match line length");

  // a full line that recovers at its CR LF reports the overflow with the length cleared
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && overflow_i
      |-> !store_valid_i
          && (line_length_i == CntW'(LINE_BYTES) || line_length_i == '0))
    else $error("overflow with store or short line");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && clear_before_i
      |-> store_valid_i && store_index_i != '0 && phase_i == PH_DONE
          && store_byte_i == CH_NUL)
    else $error("clear before outside line completion");

  a_args: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && second_arg_present_i |-> first_arg_present_i)
    else $error("second argument without first");

endmodule

bind text_command_line_tokenizer_core ctlt_checker #(.LINE_BYTES(LINE_BYTES)) u_ctlt_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .valid_i             (res_o.valid),
  .ready_i             (res_o.ready),
  .phase_i             (res_o.phase),
  .store_valid_i       (res_o.store_valid),
  .store_index_i       (res_o.store_index),
  .store_byte_i        (res_o.store_byte),
  .clear_before_i      (res_o.clear_before),
  .first_arg_present_i (res_o.first_arg_present),
  .second_arg_present_i(res_o.second_arg_present),
  .line_length_i       (res_o.line_length),
  .overflow_i          (res_o.overflow)
);

`default_nettype wire
